>>> rtl/pjb_pkg.sv
// Shared types and constants for the playout jitter buffer core.
// Register indexes, release cause codes and fixed field widths.
// No dependencies.
`timescale 1ns / 1ps

package pjb_pkg;

    localparam int TIME_W = 32;
    localparam int PKT_W  = 32;
    localparam int OCC_W  = 7;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    // configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_TAG_KIND          = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_FIRST_DELAY       = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_INTER_TIME        = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_BUFFER_LIMIT      = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_RESET_ON_OVERFLOW = 3'd4;

    // input operation codes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_ARRIVAL = 1'b1;

    typedef enum logic [1:0] {
        CAUSE_TIMED   = 2'd0,
        CAUSE_PASS    = 2'd1,
        CAUSE_PUSHOUT = 2'd2
    } cause_t;

endpackage

>>> rtl/playout_jitter_buffer_core.sv
// Playout jitter buffer core: packet FIFO with timed release, pass-through
// and overflow push-out. Depends on pjb_pkg.
`timescale 1ns / 1ps

// Takes one beat per clock cycle, ticks and arrivals alike, unless stalled as described below. A beat
// is registered on entry, decided in one pass against the queue state while
// the packet store is read at the head pointer, and its result (if any)
// is loaded into the output register when the beat is decided. The store's
// registered read port is loaded on that same edge. The input side keeps accepting
// while a result waits on m_tready; it stalls only when both registers are
// full. The store needs no clearing after reset; only written entries
// ever reach the output.
module playout_jitter_buffer_core #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration
    input  logic                      cfg_we,
    input  logic [pjb_pkg::CFG_AW-1:0] cfg_index,
    input  logic [pjb_pkg::CFG_DW-1:0] cfg_wdata,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [31:0]               s_tdata,  // [31:0] packet_data
    input  logic [8:0]                s_tuser,  // [0] operation, [8:1] tag
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [39:0]               m_tdata,  // [31:0] released_data, [38:32] occupancy
    output logic [1:0]                m_tuser   // [1:0] release_cause
);
    import pjb_pkg::*;

    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int STORE_W = (DATA_WIDTH < PKT_W) ? DATA_WIDTH : PKT_W;

    // configuration
    logic [7:0]  tag_kind_reg;
    logic [15:0] first_delay_reg;
    logic [15:0] inter_time_reg;
    logic [6:0]  buffer_limit_reg;
    logic        reset_on_overflow_reg;

    // input register
    logic               in_valid_reg, in_valid_next;
    logic               in_op_reg;
    logic [7:0]         in_tag_reg;
    logic [STORE_W-1:0] in_data_reg;

    // queue and timing state
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [TIME_W-1:0] tick_reg, tick_next;
    logic [TIME_W-1:0] last_reg, last_next;
    logic [TIME_W-1:0] due_reg, due_next;
    logic              pend_reg, pend_next;
    logic              first_reg, first_next;

    logic [STORE_W-1:0] mem [DEPTH];
    logic [STORE_W-1:0] rd_reg;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               out_mem_reg;
    logic [STORE_W-1:0] out_pass_reg;
    cause_t             out_cause_reg;
    logic [OCC_W-1:0]   out_occ_reg;

    logic              adv, step;
    logic              push, pop, emit, from_mem;
    cause_t            cause;
    logic [CW-1:0]     limit;
    logic              ovf;
    logic [TIME_W-1:0] t1, inter_ext, last_enq, set_due, elapsed, tick_gap;
    logic [AW-1:0]     head_inc, tail_inc;
    logic [31:0]       fill_ext;
    logic [OCC_W-1:0]  occ;

    assign adv      = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;

    assign inter_ext = TIME_W'(inter_time_reg);
    assign t1        = tick_reg + 1'b1;
    // release is due when the new time is at or past due_reg, by wrap-around difference
    assign tick_gap  = t1 - due_reg;
    assign head_inc  = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_inc  = (tail_reg == AW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
    assign limit     = (buffer_limit_reg == 7'd0 || 32'(buffer_limit_reg) > DEPTH)
                       ? CW'(DEPTH) : CW'(buffer_limit_reg);
    assign ovf       = fill_reg >= limit;
    // a push-out counts as a send at the current time
    assign last_enq  = ovf ? tick_reg : last_reg;
    assign elapsed   = tick_reg - last_enq;
    assign set_due   = (elapsed >= inter_ext) ? tick_reg : last_enq + inter_ext;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        tick_next  = tick_reg;
        last_next  = last_reg;
        due_next   = due_reg;
        pend_next  = pend_reg;
        first_next = first_reg;
        push       = 1'b0;
        pop        = 1'b0;
        emit       = 1'b0;
        from_mem   = 1'b1;
        cause      = CAUSE_TIMED;
        if (step) begin
            if (in_op_reg == OP_TICK) begin
                tick_next = t1;
                if (pend_reg && !tick_gap[TIME_W-1]) begin
                    pend_next = 1'b0;
                    if (fill_reg != '0) begin
                        pop       = 1'b1;
                        emit      = 1'b1;
                        last_next = t1;
                        due_next  = t1 + inter_ext;
                        pend_next = 1'b1;
                    end
                end
            end else if (in_tag_reg == tag_kind_reg) begin
                if (first_reg && fill_reg == '0 && (tick_reg - last_reg) >= inter_ext) begin
                    emit      = 1'b1;
                    from_mem  = 1'b0;
                    cause     = CAUSE_PASS;
                    last_next = tick_reg;
                end else begin
                    push = 1'b1;
                    if (ovf) begin
                        pop       = 1'b1;
                        emit      = 1'b1;
                        cause     = CAUSE_PUSHOUT;
                        last_next = tick_reg;
                    end
                    if (!first_reg) begin
                        first_next = 1'b1;
                        due_next   = tick_reg + TIME_W'(first_delay_reg);
                        pend_next  = 1'b1;
                    end else if ((ovf && reset_on_overflow_reg) || !pend_reg) begin
                        due_next  = set_due;
                        pend_next = 1'b1;
                    end
                end
            end
            if (pop)  head_next = head_inc;
            if (push) tail_next = tail_inc;
            if (push && !pop) fill_next = fill_reg + 1'b1;
            if (pop && !push) fill_next = fill_reg - 1'b1;
        end
    end

    assign fill_ext = 32'(fill_next);
    assign occ      = fill_ext[OCC_W-1:0];

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (adv) begin
            out_valid_next = step && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_kind_reg          <= '0;
            first_delay_reg       <= '0;
            inter_time_reg        <= 16'd1;
            buffer_limit_reg      <= '0;
            reset_on_overflow_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TAG_KIND:          tag_kind_reg          <= cfg_wdata[7:0];
                CFG_FIRST_DELAY:       first_delay_reg       <= cfg_wdata;
                CFG_INTER_TIME:        inter_time_reg        <= cfg_wdata;
                CFG_BUFFER_LIMIT:      buffer_limit_reg      <= cfg_wdata[6:0];
                CFG_RESET_ON_OVERFLOW: reset_on_overflow_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            tick_reg      <= '0;
            last_reg      <= '0;
            due_reg       <= '0;
            pend_reg      <= 1'b0;
            first_reg     <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            tick_reg      <= tick_next;
            last_reg      <= last_next;
            due_reg       <= due_next;
            pend_reg      <= pend_next;
            first_reg     <= first_next;
        end
    end

    // input and output payload
    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_op_reg   <= s_tuser[0];
            in_tag_reg  <= s_tuser[8:1];
            in_data_reg <= s_tdata[STORE_W-1:0];
        end
        if (adv) begin
            out_mem_reg   <= from_mem;
            out_pass_reg  <= in_data_reg;
            out_cause_reg <= cause;
            out_occ_reg   <= occ;
        end
    end

    // packet store; read at head sees the old entry when head == tail
    always_ff @(posedge aclk) begin
        if (step && push) begin
            mem[tail_reg] <= in_data_reg;
        end
        if (adv) begin
            rd_reg <= mem[head_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_cause_reg;
    assign m_tdata  = {1'b0, out_occ_reg,
                       PKT_W'(out_mem_reg ? rd_reg : out_pass_reg)};

endmodule
